>>> hdl/skst_pkg.sv
// ----------------------------------------------------------------------------
// skst_pkg: shared types and constants of the serial key sequence translator
// Holds the transaction payload structs, the action and result codes, the
// byte constants used by the matcher and the sequencer state type.
// ----------------------------------------------------------------------------
package skst_pkg;

  typedef struct packed {
    logic [1:0]  action;
    logic [10:0] table_address;
    logic [7:0]  table_byte;
    logic [7:0]  rx_byte;
    logic [7:0]  key_buffer_used;
  } item_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [6:0] scan_code;
    logic [7:0] paste_char;
    logic       paste_mode_now;
    logic       last;
  } result_t;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_RX   = 2'd1;
  localparam logic [1:0] ACT_TAKE = 2'd2;
  localparam logic [1:0] ACT_PEEK = 2'd3;

  localparam logic [2:0] KIND_PRESS   = 3'd0;
  localparam logic [2:0] KIND_RELEASE = 3'd1;
  localparam logic [2:0] KIND_PASTE   = 3'd2;
  localparam logic [2:0] KIND_EMPTY   = 3'd3;
  localparam logic [2:0] KIND_DONE    = 3'd4;

  localparam logic [7:0] ZERO_SUBST = 8'h80;
  localparam logic [7:0] SJIS_LO1   = 8'h81;
  localparam logic [7:0] SJIS_HI1   = 8'h9f;
  localparam logic [7:0] SJIS_LO2   = 8'he0;
  localparam logic [7:0] CAP_RESET  = 8'd60;

  // Event buffer: at most 63 key events are reported per transaction.
  localparam int         EV_DEPTH = 64;
  localparam int         EVW      = 6;
  localparam logic [5:0] EV_MAX   = 6'd63;

  typedef enum logic [4:0] {
    S_IDLE,
    S_TR_START,
    S_GATHER_RD,
    S_GATHER_EV,
    S_CMP_RD,
    S_CMP_EV,
    S_SKIP1_RD,
    S_SKIP1_EV,
    S_SKIP2_RD,
    S_SKIP2_EV,
    S_CNT_RD,
    S_CNT_EV,
    S_REL,
    S_EMIT_RD,
    S_EMIT_EV,
    S_EMIT_REL,
    S_PASTE_RD,
    S_PASTE_EV,
    S_DRAIN_RD,
    S_DRAIN_PUSH,
    S_FIN
  } state_t;

endpackage

>>> hdl/serial_key_sequence_translator_core.sv
// ----------------------------------------------------------------------------
// serial_key_sequence_translator_core: serial byte to key event translator
// Stores received bytes in a ring, matches pending bytes against a loaded
// table of byte strings and scan-code strings, and hands out raw characters
// in paste mode.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                          Payload
//  -------  -------------------------------  ---------------------------------
//  item     item_valid / item_ready          item (skst_pkg::item_t)
//  result   result_valid / result_ready      result (skst_pkg::result_t)
//  cfg      cfg_valid / cfg_ready            cfg_data (key buffer capacity)
//
// One item transaction is taken at a time; item_ready is high only while the
// sequencer is idle. A serial byte outside paste mode walks the table byte by
// byte, for every lookup pass and for the count and emit passes over a
// scan-code string; every table read has an address state and a state for the
// registered data of the table memory. Each event is drained through a read
// state and a push state. Results leave through an output register; each push
// waits while that register is full and the result side is stalled. Reset is
// synchronous; the table and ring memories are not cleared, so no clearing
// pass is needed.
//
module serial_key_sequence_translator_core #(
  parameter int TABLE_BYTES = 2048,
  parameter int RING_BYTES  = 1024,
  parameter int PENDING_MAX = 8,
  parameter int HELD_MAX    = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  skst_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output skst_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);

  import skst_pkg::*;

  // Table addresses carry one extra bit so that a walk past the end of the
  // table can be recognized and read as zero.
  localparam int AW  = $clog2(TABLE_BYTES);
  localparam int TW  = AW + 1;
  localparam int CW  = TW + 1;
  localparam int RW  = $clog2(RING_BYTES);
  localparam int KW  = $clog2(PENDING_MAX);
  localparam int LW  = $clog2(PENDING_MAX + 1);
  localparam int HW  = (HELD_MAX > 1) ? $clog2(HELD_MAX) : 1;
  localparam int HCW = $clog2(HELD_MAX + 1);

  // Control state.
  state_t         state, state_next;
  logic [RW-1:0]  rd_idx, rd_idx_next;
  logic [RW-1:0]  wr_idx, wr_idx_next;
  logic           paste, paste_next;
  logic           sjis, sjis_next;
  logic [HCW-1:0] held, held_next;
  logic [7:0]     cap;
  logic [EVW-1:0] ev_cnt, ev_cnt_next;
  logic [EVW-1:0] di, di_next;

  // Per-transaction working registers.
  logic [1:0]     act, act_next;
  logic [7:0]     used, used_next;
  logic [RW-1:0]  rp, rp_next;
  logic [LW-1:0]  len, len_next;
  logic [LW-1:0]  off, off_next;
  logic [LW-1:0]  kl, kl_next;
  logic [LW-1:0]  k, k_next;
  logic [LW-1:0]  mlen, mlen_next;
  logic           found, found_next;
  logic           part, part_next;
  logic           to_paste, to_paste_next;
  logic [TW-1:0]  ta, ta_next;
  logic [TW-1:0]  pos, pos_next;
  logic [CW-1:0]  cnt, cnt_next;
  logic [2:0]     fin_kind, fin_kind_next;
  logic [7:0]     fin_char, fin_char_next;
  logic [7:0]     keys [PENDING_MAX];
  logic [7:0]     keys_next [PENDING_MAX];
  logic [6:0]     held_keys [HELD_MAX];
  logic [6:0]     held_keys_next [HELD_MAX];

  // Memory ports.
  logic          t_we, t_re;
  logic [7:0]    t_rdata, tbyte;
  logic          r_we, r_re;
  logic [RW-1:0] r_raddr;
  logic [7:0]    r_wdata, r_rdata;
  logic          ev_we, ev_re;
  logic [7:0]    ev_wdata, ev_rdata;

  // Event write request from the sequencer.
  logic          emit, emit_rel;
  logic [6:0]    emit_code;

  logic          push, space;
  result_t       push_data;

  logic [RW:0]   pending;
  logic [LW-1:0] kidx;
  logic          fit_fail;

  function automatic logic [RW-1:0] ring_nxt(input logic [RW-1:0] p);
    ring_nxt = (p == RW'(RING_BYTES - 1)) ? '0 : p + 1'b1;
  endfunction

  assign item_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_valid) begin
      cap <= cfg_data;
    end
  end

  // Table memory: written by load transactions, read by the matcher.
  assign t_we = item_valid && item_ready && (item.action == ACT_LOAD) &&
                (32'(item.table_address) < TABLE_BYTES);

  skst_ram #(.WIDTH(8), .DEPTH(TABLE_BYTES)) u_table (
    .clk   (clk),
    .we    (t_we),
    .waddr (AW'(item.table_address)),
    .wdata (item.table_byte),
    .re    (t_re),
    .raddr (ta[AW-1:0]),
    .rdata (t_rdata)
  );

  // Anything past the end of the table reads as a terminator.
  assign tbyte = (ta >= TW'(TABLE_BYTES)) ? 8'h00 : t_rdata;

  // Ring memory: a received zero is stored as 0x80.
  assign r_we    = item_valid && item_ready && (item.action == ACT_RX);
  assign r_wdata = (item.rx_byte == 8'h00) ? ZERO_SUBST : item.rx_byte;

  skst_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_ring (
    .clk   (clk),
    .we    (r_we),
    .waddr (wr_idx),
    .wdata (r_wdata),
    .re    (r_re),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  // Event buffer: bit 7 marks a release, bits 6:0 carry the scan code. All
  // events of a transaction are collected here first, so that each of them
  // can report the paste mode that holds at the end of the transaction.
  assign ev_we    = emit && (ev_cnt != EV_MAX);
  assign ev_wdata = {emit_rel, emit_code};

  skst_ram #(.WIDTH(8), .DEPTH(EV_DEPTH)) u_events (
    .clk   (clk),
    .we    (ev_we),
    .waddr (ev_cnt),
    .wdata (ev_wdata),
    .re    (ev_re),
    .raddr (di),
    .rdata (ev_rdata)
  );

  skst_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .space     (space),
    .valid     (result_valid),
    .ready     (result_ready),
    .data      (result)
  );

  // Bytes waiting in the ring between the read and write indexes.
  assign pending = (wr_idx >= rd_idx) ?
                   ({1'b0, wr_idx} - {1'b0, rd_idx}) :
                   ({1'b0, wr_idx} + (RW + 1)'(RING_BYTES) - {1'b0, rd_idx});

  assign kidx = off + k;

  // A sequence fits when the free key buffer slots cover the held keys plus
  // every non-shift code of the string; an overfull buffer never fits.
  assign fit_fail = (used > cap) || (CW'(cap - used) < cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_idx <= '0;
      wr_idx <= '0;
      paste  <= 1'b0;
      sjis   <= 1'b0;
      held   <= '0;
      ev_cnt <= '0;
      di     <= '0;
    end else begin
      state  <= state_next;
      rd_idx <= rd_idx_next;
      wr_idx <= wr_idx_next;
      paste  <= paste_next;
      sjis   <= sjis_next;
      held   <= held_next;
      ev_cnt <= ev_cnt_next;
      di     <= di_next;
    end
  end

  always_ff @(posedge clk) begin
    act       <= act_next;
    used      <= used_next;
    rp        <= rp_next;
    len       <= len_next;
    off       <= off_next;
    kl        <= kl_next;
    k         <= k_next;
    mlen      <= mlen_next;
    found     <= found_next;
    part      <= part_next;
    to_paste  <= to_paste_next;
    ta        <= ta_next;
    pos       <= pos_next;
    cnt       <= cnt_next;
    fin_kind  <= fin_kind_next;
    fin_char  <= fin_char_next;
    keys      <= keys_next;
    held_keys <= held_keys_next;
  end

  always_comb begin
    state_next     = state;
    rd_idx_next    = rd_idx;
    wr_idx_next    = wr_idx;
    paste_next     = paste;
    sjis_next      = sjis;
    held_next      = held;
    ev_cnt_next    = ev_cnt;
    di_next        = di;
    act_next       = act;
    used_next      = used;
    rp_next        = rp;
    len_next       = len;
    off_next       = off;
    kl_next        = kl;
    k_next         = k;
    mlen_next      = mlen;
    found_next     = found;
    part_next      = part;
    to_paste_next  = to_paste;
    ta_next        = ta;
    pos_next       = pos;
    cnt_next       = cnt;
    fin_kind_next  = fin_kind;
    fin_char_next  = fin_char;
    keys_next      = keys;
    held_keys_next = held_keys;
    t_re           = 1'b0;
    r_re           = 1'b0;
    r_raddr        = rp;
    ev_re          = 1'b0;
    emit           = 1'b0;
    emit_rel       = 1'b0;
    emit_code      = '0;
    push           = 1'b0;
    push_data      = '0;

    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          act_next      = item.action;
          used_next     = item.key_buffer_used;
          ev_cnt_next   = '0;
          di_next       = '0;
          fin_kind_next = KIND_DONE;
          fin_char_next = 8'h00;
          unique case (item.action)
            ACT_LOAD: begin
              state_next = S_FIN;
            end
            ACT_RX: begin
              // A full ring keeps the write index; the byte is lost.
              if (ring_nxt(wr_idx) != rd_idx) begin
                wr_idx_next = ring_nxt(wr_idx);
              end
              state_next = paste ? S_FIN : S_TR_START;
            end
            default: begin
              if (!paste || (rd_idx == wr_idx)) begin
                fin_kind_next = KIND_EMPTY;
                state_next    = S_FIN;
              end else begin
                state_next = S_PASTE_RD;
              end
            end
          endcase
        end
      end

      S_TR_START: begin
        if (pending > (RW + 1)'(PENDING_MAX)) begin
          to_paste_next = 1'b1;
          state_next    = S_REL;
        end else begin
          rp_next    = rd_idx;
          len_next   = '0;
          state_next = S_GATHER_RD;
        end
      end

      S_GATHER_RD: begin
        r_re       = 1'b1;
        r_raddr    = rp;
        state_next = S_GATHER_EV;
      end

      S_GATHER_EV: begin
        if (r_rdata > ZERO_SUBST) begin
          to_paste_next = 1'b1;
          state_next    = S_REL;
        end else begin
          keys_next[len[KW-1:0]] = r_rdata;
          len_next = len + 1'b1;
          rp_next  = ring_nxt(rp);
          if (ring_nxt(rp) == wr_idx) begin
            // All pending bytes gathered: start the prefix-aware lookup.
            part_next  = 1'b1;
            off_next   = '0;
            kl_next    = len + 1'b1;
            ta_next    = '0;
            k_next     = '0;
            mlen_next  = '0;
            found_next = 1'b0;
            state_next = S_CMP_RD;
          end else begin
            state_next = S_GATHER_RD;
          end
        end
      end

      S_CMP_RD: begin
        t_re       = 1'b1;
        state_next = S_CMP_EV;
      end

      S_CMP_EV: begin
        if ((k == '0) && (tbyte == 8'h00)) begin
          // End of table: the lookup pass is over.
          if (part) begin
            if (found) begin
              ta_next    = pos;
              cnt_next   = CW'(held);
              state_next = S_CNT_RD;
            end else begin
              // No match at all: fall back to greedy longest prefixes.
              part_next  = 1'b0;
              off_next   = '0;
              kl_next    = len;
              ta_next    = '0;
              mlen_next  = '0;
              found_next = 1'b0;
              state_next = S_CMP_RD;
            end
          end else if (!found) begin
            rd_idx_next = wr_idx;
            state_next  = S_DRAIN_RD;
          end else begin
            ta_next    = pos;
            cnt_next   = CW'(held);
            state_next = S_CNT_RD;
          end
        end else if ((k < kl) && (tbyte == keys[kidx[KW-1:0]])) begin
          ta_next    = ta + 1'b1;
          k_next     = k + 1'b1;
          state_next = S_CMP_RD;
        end else begin
          ta_next    = ta + 1'b1;
          k_next     = '0;
          state_next = (tbyte == 8'h00) ? S_SKIP2_RD : S_SKIP1_RD;
          if (part) begin
            if (k == kl) begin
              if (tbyte != 8'h00) begin
                // The pending bytes are a proper prefix: wait for more.
                state_next = S_DRAIN_RD;
              end else if (!found) begin
                found_next = 1'b1;
                mlen_next  = kl;
                pos_next   = ta + 1'b1;
              end
            end
          end else if ((tbyte == 8'h00) && (mlen < k)) begin
            found_next = 1'b1;
            mlen_next  = k;
            pos_next   = ta + 1'b1;
          end
        end
      end

      S_SKIP1_RD: begin
        t_re       = 1'b1;
        state_next = S_SKIP1_EV;
      end

      S_SKIP1_EV: begin
        ta_next    = ta + 1'b1;
        state_next = (tbyte == 8'h00) ? S_SKIP2_RD : S_SKIP1_RD;
      end

      S_SKIP2_RD: begin
        t_re       = 1'b1;
        state_next = S_SKIP2_EV;
      end

      S_SKIP2_EV: begin
        ta_next    = ta + 1'b1;
        state_next = (tbyte == 8'h00) ? S_CMP_RD : S_SKIP2_RD;
      end

      S_CNT_RD: begin
        t_re       = 1'b1;
        state_next = S_CNT_EV;
      end

      S_CNT_EV: begin
        if (tbyte == 8'h00) begin
          to_paste_next = fit_fail;
          state_next    = S_REL;
        end else begin
          if (!tbyte[7]) begin
            cnt_next = cnt + 1'b1;
          end
          ta_next    = ta + 1'b1;
          state_next = S_CNT_RD;
        end
      end

      S_REL: begin
        if (held != '0) begin
          held_next = held - 1'b1;
          emit      = 1'b1;
          emit_rel  = 1'b1;
          emit_code = held_keys[HW'(held - 1'b1)];
        end else if (to_paste) begin
          paste_next = 1'b1;
          state_next = S_DRAIN_RD;
        end else begin
          ta_next    = pos;
          state_next = S_EMIT_RD;
        end
      end

      S_EMIT_RD: begin
        t_re       = 1'b1;
        state_next = S_EMIT_EV;
      end

      S_EMIT_EV: begin
        if (tbyte == 8'h00) begin
          if (part || (kl == mlen)) begin
            rd_idx_next = wr_idx;
            state_next  = S_DRAIN_RD;
          end else begin
            off_next   = off + mlen;
            kl_next    = kl - mlen;
            ta_next    = '0;
            k_next     = '0;
            mlen_next  = '0;
            found_next = 1'b0;
            state_next = S_CMP_RD;
          end
        end else if (tbyte[7]) begin
          // Shift-type key: pressed now, released before the next sequence.
          emit      = 1'b1;
          emit_code = tbyte[6:0];
          if (held < HCW'(HELD_MAX)) begin
            held_keys_next[HW'(held)] = tbyte[6:0];
            held_next = held + 1'b1;
          end
          ta_next    = ta + 1'b1;
          state_next = S_EMIT_RD;
        end else begin
          emit       = 1'b1;
          emit_code  = tbyte[6:0];
          state_next = S_EMIT_REL;
        end
      end

      S_EMIT_REL: begin
        emit       = 1'b1;
        emit_rel   = 1'b1;
        emit_code  = tbyte[6:0];
        ta_next    = ta + 1'b1;
        state_next = S_EMIT_RD;
      end

      S_PASTE_RD: begin
        r_re       = 1'b1;
        r_raddr    = rd_idx;
        state_next = S_PASTE_EV;
      end

      S_PASTE_EV: begin
        fin_kind_next = KIND_PASTE;
        fin_char_next = r_rdata;
        if (act == ACT_TAKE) begin
          // The byte after a Shift-JIS lead byte keeps paste mode alive.
          if (sjis) begin
            sjis_next = 1'b0;
          end else begin
            sjis_next = ((r_rdata >= SJIS_LO1) && (r_rdata <= SJIS_HI1)) ||
                        (r_rdata >= SJIS_LO2);
          end
          rd_idx_next = ring_nxt(rd_idx);
          if ((ring_nxt(rd_idx) == wr_idx) && !sjis_next) begin
            paste_next = 1'b0;
          end
        end
        state_next = S_FIN;
      end

      S_DRAIN_RD: begin
        if (di == ev_cnt) begin
          state_next = S_FIN;
        end else begin
          ev_re      = 1'b1;
          state_next = S_DRAIN_PUSH;
        end
      end

      S_DRAIN_PUSH: begin
        if (space) begin
          push                     = 1'b1;
          push_data.result_kind    = ev_rdata[7] ? KIND_RELEASE : KIND_PRESS;
          push_data.scan_code      = ev_rdata[6:0];
          push_data.paste_mode_now = paste;
          di_next                  = di + 1'b1;
          state_next               = S_DRAIN_RD;
        end
      end

      S_FIN: begin
        if (space) begin
          push                     = 1'b1;
          push_data.result_kind    = fin_kind;
          push_data.paste_char     = fin_char;
          push_data.paste_mode_now = paste;
          push_data.last           = 1'b1;
          state_next               = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (ev_we) begin
      ev_cnt_next = ev_cnt + 1'b1;
    end
  end

endmodule

>>> hdl/skst_ram.sv
// ----------------------------------------------------------------------------
// skst_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds its
// value while no read is requested.
// ----------------------------------------------------------------------------
module skst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/skst_out_reg.sv
// ----------------------------------------------------------------------------
// skst_out_reg: result output register
// Holds one result transaction for the downstream side and tells the
// sequencer when it can take another one.
// ----------------------------------------------------------------------------
module skst_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  skst_pkg::result_t push_data,
  output logic              space,
  output logic              valid,
  input  logic              ready,
  output skst_pkg::result_t data
);

  import skst_pkg::*;

  assign space = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (space) begin
      valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (space && push) begin
      data <= push_data;
    end
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the serial key sequence translator core
// Loads match tables, sends serial bytes and paste takes and peeks, and
// checks every result against a predictor running alongside the block.
// The item side sends in bursts and the result side stalls on a pattern.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import skst_pkg::*;

  localparam int TBL_N   = 2048;
  localparam int RING_N  = 1024;
  localparam int PEND_N  = 8;
  localparam int HELD_N  = 8;
  localparam int CYC_MAX = 4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;

  always #1 clk = ~clk;

  serial_key_sequence_translator_core u_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Shadow state of the block, kept by the predictor.
  logic [7:0] sh_table [TBL_N];
  logic [7:0] sh_ring [RING_N];
  int unsigned sh_rd, sh_wr, sh_held_n, sh_cap, sh_used;
  logic sh_paste, sh_sjis;
  logic [7:0] sh_held [HELD_N];

  // Events of the step being predicted, and the store of expected results.
  result_t step_ev [$];
  result_t expected_q [$];

  int errors = 0;
  int cycles = 0;
  bit stall_on = 1'b1;

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic logic [7:0] tbl(int unsigned a);
    return a < TBL_N ? sh_table[a] : 8'h00;
  endfunction

  function automatic int unsigned ring_inc(int unsigned p);
    return (p + 1 >= RING_N) ? 0 : p + 1;
  endfunction

  function automatic void add_event(logic [2:0] kind, logic [6:0] code);
    result_t r;
    if (step_ev.size() < EV_DEPTH - 1) begin
      r = '0;
      r.result_kind = kind;
      r.scan_code = code;
      step_ev.push_back(r);
    end
  endfunction

  function automatic void release_all();
    while (sh_held_n > 0) begin
      sh_held_n--;
      add_event(KIND_RELEASE, sh_held[sh_held_n][6:0]);
    end
  endfunction

  // Emits the scan-code string at pos if it fits the host key buffer.
  function automatic bit send_codes(int unsigned pos);
    int cnt;
    int unsigned p;
    logic [7:0] c;
    cnt = sh_held_n;
    for (p = pos; tbl(p) != 0; p++) begin
      c = tbl(p);
      if (!c[7]) cnt++;
    end
    if (int'(sh_cap) - int'(sh_used) < cnt) return 1'b0;
    release_all();
    for (p = pos; tbl(p) != 0; p++) begin
      c = tbl(p);
      if (c[7]) begin
        add_event(KIND_PRESS, c[6:0]);
        if (sh_held_n < HELD_N) begin
          sh_held[sh_held_n] = c;
          sh_held_n++;
        end
      end else begin
        add_event(KIND_PRESS, c[6:0]);
        add_event(KIND_RELEASE, c[6:0]);
      end
    end
    return 1'b1;
  endfunction

  // Table search: 0 no match, 1 partial, 2 match with codes at pos.
  function automatic int search(input logic [7:0] keys [PEND_N], int unsigned off,
                                int unsigned klen, bit part, output int unsigned mlen,
                                inout int unsigned pos);
    int unsigned m, k, kl;
    int found;
    m = 0; mlen = 0; found = 0;
    while (tbl(m) != 0) begin
      k = 0; kl = klen;
      while (kl > 0 && tbl(m) == keys[off + k]) begin
        m++; k++; kl--;
      end
      if (part) begin
        if (kl == 0) begin
          if (tbl(m) != 0) return 1;
          if (mlen < klen) begin
            mlen = klen; pos = m + 1; found = 2;
          end
        end
      end else if (tbl(m) == 0 && mlen < klen - kl) begin
        mlen = klen - kl; pos = m + 1; found = 2;
      end
      while (tbl(m) != 0) m++;
      m++;
      while (tbl(m) != 0) m++;
      m++;
    end
    return found;
  endfunction

  function automatic void match_pending();
    logic [7:0] keys [PEND_N];
    int unsigned len, p, ml, pos, off, kl;
    int r;
    logic [7:0] c;
    len = 0; p = sh_rd; pos = 0;
    foreach (keys[i]) keys[i] = 8'h00;
    while (p != sh_wr) begin
      c = sh_ring[p];
      p = ring_inc(p);
      len++;
      if (c > ZERO_SUBST || len > PEND_N) begin
        release_all(); sh_paste = 1'b1;
        return;
      end
      keys[len - 1] = c;
    end
    r = search(keys, 0, len, 1'b1, ml, pos);
    if (r == 1) return;
    if (r == 2) begin
      if (!send_codes(pos)) begin
        release_all(); sh_paste = 1'b1;
        return;
      end
    end else begin
      off = 0; kl = len;
      while (kl > 0) begin
        if (search(keys, off, kl, 1'b0, ml, pos) == 0 || ml == 0) break;
        if (!send_codes(pos)) begin
          release_all(); sh_paste = 1'b1;
          return;
        end
        off += ml; kl -= ml;
      end
    end
    repeat (len) sh_rd = ring_inc(sh_rd);
  endfunction

  // Works out every result of one item and queues them as expectations.
  function automatic void predict_item(item_t it);
    result_t r;
    logic [7:0] c;
    int unsigned nw;
    step_ev.delete();
    sh_used = it.key_buffer_used;
    r = '0;
    if (it.action == ACT_LOAD) begin
      sh_table[it.table_address] = it.table_byte;
      r.result_kind = KIND_DONE;
      step_ev.push_back(r);
    end else if (it.action == ACT_RX) begin
      c = (it.rx_byte == 8'h00) ? ZERO_SUBST : it.rx_byte;
      sh_ring[sh_wr] = c;
      nw = ring_inc(sh_wr);
      if (nw != sh_rd) sh_wr = nw;
      if (!sh_paste) match_pending();
      r.result_kind = KIND_DONE;
      step_ev.push_back(r);
    end else if (!sh_paste || sh_rd == sh_wr) begin
      r.result_kind = KIND_EMPTY;
      step_ev.push_back(r);
    end else if (it.action == ACT_PEEK) begin
      r.result_kind = KIND_PASTE;
      r.paste_char = sh_ring[sh_rd];
      step_ev.push_back(r);
    end else begin
      c = sh_ring[sh_rd];
      if (sh_sjis) sh_sjis = 1'b0;
      else if ((c >= SJIS_LO1 && c <= SJIS_HI1) || c >= SJIS_LO2) sh_sjis = 1'b1;
      sh_rd = ring_inc(sh_rd);
      if (sh_rd == sh_wr && !sh_sjis) sh_paste = 1'b0;
      r.result_kind = KIND_PASTE;
      r.paste_char = c;
      step_ev.push_back(r);
    end
    foreach (step_ev[i]) begin
      r = step_ev[i];
      r.paste_mode_now = sh_paste;
      r.last = (i == step_ev.size() - 1);
      expected_q.push_back(r);
    end
  endfunction

  // Sends one item; valid stays up until the block accepts it. The
  // block is busy in the cycle after an accept, so the trailing wait costs
  // no throughput.
  task automatic send_item(item_t it);
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    predict_item(it);
    item_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Burst pacing: random gaps between bursts of random length.
  int burst_left = 0;
  task automatic paced_send(item_t it);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    send_item(it);
  endtask

  function automatic item_t mk(logic [1:0] act, logic [10:0] a, logic [7:0] b,
                               logic [7:0] rx, logic [7:0] used);
    item_t it;
    it.action = act; it.table_address = a; it.table_byte = b;
    it.rx_byte = rx; it.key_buffer_used = used;
    return it;
  endfunction

  task automatic load_byte(int unsigned a, logic [7:0] b);
    paced_send(mk(ACT_LOAD, a[10:0], b, 8'($urandom), 8'($urandom)));
  endtask

  task automatic rx_byte_send(logic [7:0] b, logic [7:0] used);
    paced_send(mk(ACT_RX, 11'($urandom), 8'($urandom), b, used));
  endtask

  task automatic paste_op(logic [1:0] act);
    paced_send(mk(act, 11'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
  endtask

  // Takes paste characters until paste mode ends. A lead byte taken last
  // keeps paste mode with an empty ring, so a plain byte is fed to finish it.
  task automatic leave_paste();
    while (sh_paste) begin
      if (sh_rd == sh_wr) rx_byte_send(8'h41, 8'd0);
      else paste_op(ACT_TAKE);
    end
  endtask

  // Waits for every expected result, then a settling pause.
  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_capacity(logic [7:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sh_cap = v;
  endtask

  // Writes a table image from a byte list and adds two zero bytes so no
  // read past the written part ever touches an unwritten entry.
  task automatic load_table(input logic [7:0] img [$]);
    foreach (img[i]) load_byte(i, img[i]);
    for (int i = img.size(); i < img.size() + 2; i++) load_byte(i, 8'h00);
  endtask

  // Table: "a"->x, "ab"->shift+y, "q"->z, long 8-byte entry, 0x80 entry.
  task automatic test_directed();
    logic [7:0] img [$];
    img = '{8'h61, 8'h00, 8'h11, 8'h00,
            8'h61, 8'h62, 8'h00, 8'hAA, 8'h12, 8'h00,
            8'h71, 8'h00, 8'h7F, 8'h13, 8'h00,
            8'h80, 8'h00, 8'h01, 8'h00,
            8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h00,
            8'h14, 8'h00};
    load_table(img);
    // Every 11-bit address lies in the table range; writes within range here.
    rx_byte_send(8'h61, 8'd0);   // partial match waits
    rx_byte_send(8'h62, 8'd0);   // full match with a held shift
    rx_byte_send(8'h71, 8'd0);   // releases the shift first
    rx_byte_send(8'h00, 8'd0);   // zero stored as 0x80
    rx_byte_send(8'h61, 8'd0);
    rx_byte_send(8'h71, 8'd0);   // no match: greedy pieces
    rx_byte_send(8'h7A, 8'd0);   // unmatched byte dropped
    rx_byte_send(8'h71, 8'd255); // overfull key buffer: paste mode
    paste_op(ACT_PEEK);
    paste_op(ACT_TAKE);
    paste_op(ACT_TAKE);          // empty
    rx_byte_send(8'h81, 8'd0);   // high byte: paste mode, lead byte
    rx_byte_send(8'hFF, 8'd0);   // stored only
    paste_op(ACT_TAKE);
    paste_op(ACT_TAKE);
    paste_op(ACT_PEEK);
    for (int i = 0; i < 9; i++) rx_byte_send(8'h31 + i[7:0], 8'd0); // fills the 8-byte entry, then one unmatched byte
    drain();                      // sender holds off until all results arrive
    leave_paste();
  endtask

  task automatic test_capacity();
    write_capacity(8'd1);
    rx_byte_send(8'h71, 8'd0);   // needs two slots: does not fit
    rx_byte_send(8'h71, 8'd1);   // stored in paste mode
    leave_paste();
    write_capacity(8'd255);
    rx_byte_send(8'h71, 8'd255);
    write_capacity(CAP_RESET);
  endtask

  // Random tables with small alphabets so matches are frequent.
  task automatic test_random(int n_items);
    logic [7:0] img [$];
    int n_ent, sent;
    sent = 0;
    while (sent < n_items) begin
      drain();
      img.delete();
      n_ent = $urandom_range(1, 5);
      for (int e = 0; e < n_ent; e++) begin
        repeat ($urandom_range(1, 3)) img.push_back(8'h41 + 8'($urandom_range(0, 3)));
        img.push_back(8'h00);
        repeat ($urandom_range(0, 4))
          img.push_back(8'($urandom_range(1, 255)));
        img.push_back(8'h00);
      end
      img.push_back(8'h00);
      load_table(img);
      if ($urandom_range(0, 2) == 0) write_capacity(8'($urandom_range(1, 255)));
      repeat (30) begin
        case ($urandom_range(0, 9))
          0: rx_byte_send(8'($urandom), 8'($urandom));
          1: paste_op(ACT_PEEK);
          2, 3: paste_op(ACT_TAKE);
          default: rx_byte_send(8'h41 + 8'($urandom_range(0, 4)),
                                8'($urandom_range(0, 70)));
        endcase
        sent++;
      end
      leave_paste();
    end
    // An address with its top bit set still lands in the table range.
    drain();
    load_byte(11'h7FF, 8'h00);
  endtask

  // Result side: stalls on an on/off pattern, with a stretch of no stalls.
  always @(posedge clk) begin
    if (rst) result_ready <= 1'b0;
    else if (!stall_on) result_ready <= 1'b1;
    else result_ready <= (cycles % 11) < 7 || (cycles % 37) == 3;
  end

  // Result checker.
  result_t exp_r;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && result_valid && result_ready) begin
      if (expected_q.size() == 0) report_mismatch("result with nothing expected");
      else begin
        exp_r = expected_q.pop_front();
        if (result.result_kind !== exp_r.result_kind)
          report_mismatch($sformatf("kind %0d want %0d", result.result_kind,
                                    exp_r.result_kind));
        if (result.scan_code !== exp_r.scan_code)
          report_mismatch($sformatf("code %h want %h", result.scan_code,
                                    exp_r.scan_code));
        if (result.paste_char !== exp_r.paste_char)
          report_mismatch($sformatf("char %h want %h", result.paste_char,
                                    exp_r.paste_char));
        if (result.paste_mode_now !== exp_r.paste_mode_now)
          report_mismatch("paste mode flag");
        if (result.last !== exp_r.last) report_mismatch("last flag");
      end
    end
    if (cycles > CYC_MAX) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    sh_rd = 0; sh_wr = 0; sh_held_n = 0; sh_cap = CAP_RESET; sh_used = 0;
    sh_paste = 1'b0; sh_sjis = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_capacity();
    stall_on = 1'b0;
    test_random(60);
    stall_on = 1'b1;
    test_random(60);
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
